>>> rtl/vtg_pkg.sv
`default_nettype none

package vtg_pkg;

  typedef enum logic [1:0] {
    MODE_OFF       = 2'd0,
    MODE_SMOOTH    = 2'd1,
    MODE_CHROMATIC = 2'd2,
    MODE_MAJOR     = 2'd3
  } vtg_mode_t;

  typedef enum logic [1:0] {
    CLS_CLIMB = 2'd0,
    CLS_SINK  = 2'd1,
    CLS_DEAD  = 2'd2
  } vtg_class_t;

  localparam logic [1:0] REG_TONE_MODE       = 2'd0;
  localparam logic [1:0] REG_CLIMB_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_SINK_THRESHOLD  = 2'd2;
  localparam logic [1:0] REG_STOP_MUTE       = 2'd3;

  localparam logic signed [15:0] CLIMB_THRESHOLD_RESET = 16'sd200;
  localparam logic signed [15:0] SINK_THRESHOLD_RESET  = -16'sd2000;

  localparam logic [10:0] TONE_LIMIT = 11'd2000;
  localparam logic [10:0] TONE_MAX   = 11'd2047;

  typedef struct packed {
    logic signed [15:0] measured_climb;
    logic signed [15:0] test_climb;
    logic               test_active;
    logic               fix_ok;
    logic               ground_stopped;
    logic [7:0]         elapsed_ticks;
  } vtg_item_t;

  typedef struct packed {
    logic [10:0] tone_value;
    logic        tone_written;
    logic        sound_on;
  } vtg_result_t;

  typedef struct packed {
    vtg_mode_t          mode;
    logic signed [15:0] climb_threshold;
    logic signed [15:0] sink_threshold;
    logic               stop_mute;
  } vtg_cfg_t;

  typedef struct packed {
    logic signed [15:0] up;
    logic [7:0]         ticks;
    logic               mute;
    vtg_class_t         cls;
    logic [10:0]        tone;
    logic [7:0]         period;
  } vtg_work_t;

  function automatic logic [10:0] note_value(input logic [3:0] idx);
    logic [10:0] v;
    unique case (idx)
      4'd0:    v = 11'd2004;
      4'd1:    v = 11'd1891;
      4'd2:    v = 11'd1785;
      4'd3:    v = 11'd1685;
      4'd4:    v = 11'd1591;
      4'd5:    v = 11'd1501;
      4'd6:    v = 11'd1417;
      4'd7:    v = 11'd1337;
      4'd8:    v = 11'd1262;
      4'd9:    v = 11'd1192;
      4'd10:   v = 11'd1125;
      4'd11:   v = 11'd1061;
      default: v = 11'd0;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] major_note(input logic [2:0] idx);
    logic [3:0] n;
    unique case (idx)
      3'd0:    n = 4'd0;
      3'd1:    n = 4'd2;
      3'd2:    n = 4'd4;
      3'd3:    n = 4'd5;
      3'd4:    n = 4'd7;
      3'd5:    n = 4'd9;
      default: n = 4'd11;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/vtg_front.sv
`default_nettype none

module vtg_front
  import vtg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire vtg_item_t item,
  input  wire vtg_cfg_t  cfg,
  output logic           push,
  output vtg_work_t      work
);

  logic               s1_valid;
  logic signed [15:0] s1_up;
  logic [7:0]         s1_ticks;
  logic               s1_mute;

  logic               is_climb;
  logic               is_sink;
  logic               major;
  logic               use_scale;
  vtg_class_t         cls;
  logic signed [15:0] thr;
  logic signed [17:0] x;
  logic               x_big;
  logic [14:0]        x_low;
  logic [15:0]        q_recip;
  logic [30:0]        q_prod;
  logic [3:0]         q;
  logic signed [13:0] smooth_climb;
  logic signed [13:0] smooth_sink;
  logic [10:0]        smooth_tone;
  logic signed [15:0] half;
  logic signed [16:0] t;
  logic [7:0]         period;

  logic               s2_valid;
  logic signed [15:0] s2_up;
  logic [7:0]         s2_ticks;
  logic               s2_mute;
  vtg_class_t         s2_cls;
  logic [10:0]        s2_smooth;
  logic [7:0]         s2_period;
  logic               s2_neg;
  logic               s2_big;
  logic [14:0]        s2_low;
  logic [3:0]         s2_q;
  logic               s2_major;
  logic               s2_scale;
  logic [15:0]        rem_w;

  logic               s3_valid;
  logic signed [15:0] s3_up;
  logic [7:0]         s3_ticks;
  logic               s3_mute;
  vtg_class_t         s3_cls;
  logic [10:0]        s3_smooth;
  logic [7:0]         s3_period;
  logic               s3_neg;
  logic               s3_big;
  logic [3:0]         s3_q;
  logic               s3_major;
  logic               s3_scale;
  logic [10:0]        s3_rem;

  logic [21:0]        prod_c;
  logic [21:0]        prod_m;
  logic [2:0]         n_major;
  logic [3:0]         note_idx;
  logic [10:0]        note_base;
  logic [10:0]        v;
  logic [11:0]        diff;
  logic [10:0]        scale_tone;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_up    <= item.test_active ? item.test_climb : item.measured_climb;
    s1_ticks <= item.elapsed_ticks;
    s1_mute  <= (cfg.mode == MODE_OFF) ||
                (!item.test_active &&
                 (!item.fix_ok || (item.ground_stopped && cfg.stop_mute)));
  end

  always_comb begin
    is_climb  = s1_up >= cfg.climb_threshold;
    is_sink   = s1_up <= cfg.sink_threshold;
    major     = cfg.mode == MODE_MAJOR;
    use_scale = (cfg.mode == MODE_CHROMATIC) || (cfg.mode == MODE_MAJOR);
    if (is_climb) begin
      cls = CLS_CLIMB;
    end else if (is_sink) begin
      cls = CLS_SINK;
    end else begin
      cls = CLS_DEAD;
    end
    thr   = is_climb ? cfg.climb_threshold : cfg.sink_threshold;
    x     = 18'(s1_up) + (major ? 18'sd4000 : 18'sd2000) - 18'(thr);
    x_big = !x[17] && (x >= (major ? 18'sd32000 : 18'sd16000));
    x_low = x[14:0];

    // Octave by reciprocal multiply; exact over the range where it matters.
    q_recip = major ? 16'd33555 : 16'd16778;
    q_prod  = 31'(x_low) * 31'(q_recip);
    q       = major ? q_prod[29:26] : q_prod[27:24];

    smooth_climb = 14'sd1600 + 14'(s1_up >>> 4);
    smooth_sink  = 14'sd1500 + 14'(s1_up >>> 3);
    if (is_climb) begin
      if (smooth_climb < 14'sd0) begin
        smooth_tone = 11'd0;
      end else if (smooth_climb > 14'sd2000) begin
        smooth_tone = TONE_LIMIT;
      end else begin
        smooth_tone = smooth_climb[10:0];
      end
    end else begin
      if (smooth_sink < 14'sd0) begin
        smooth_tone = 11'd0;
      end else if (smooth_sink > 14'sd2047) begin
        smooth_tone = TONE_MAX;
      end else begin
        smooth_tone = smooth_sink[10:0];
      end
    end

    // Halving rounds toward zero.
    half   = (s1_up + $signed({15'd0, s1_up[15]})) >>> 1;
    t      = 17'sd3840 - 17'(half);
    period = (t < 17'sd128) ? 8'd1 : t[14:7];
  end

  always_ff @(posedge clk) begin
    s2_up     <= s1_up;
    s2_ticks  <= s1_ticks;
    s2_mute   <= s1_mute;
    s2_cls    <= cls;
    s2_smooth <= smooth_tone;
    s2_period <= period;
    s2_neg    <= x[17];
    s2_big    <= x_big;
    s2_low    <= x_low;
    s2_q      <= q;
    s2_major  <= major;
    s2_scale  <= use_scale;
  end

  assign rem_w = 16'(s2_low) - 16'(s2_q) * (s2_major ? 16'd2000 : 16'd1000);

  always_ff @(posedge clk) begin
    s3_up     <= s2_up;
    s3_ticks  <= s2_ticks;
    s3_mute   <= s2_mute;
    s3_cls    <= s2_cls;
    s3_smooth <= s2_smooth;
    s3_period <= s2_period;
    s3_neg    <= s2_neg;
    s3_big    <= s2_big;
    s3_q      <= s2_q;
    s3_major  <= s2_major;
    s3_scale  <= s2_scale;
    s3_rem    <= rem_w[10:0];
  end

  always_comb begin
    prod_c   = 22'(s3_rem) * 22'd1561;
    prod_m   = 22'(s3_rem) * 22'd917;
    n_major  = (prod_m[20:18] > 3'd6) ? 3'd6 : prod_m[20:18];
    note_idx = s3_major ? major_note(n_major) : prod_c[20:17];
    note_base = note_value(note_idx);
    v        = note_base >> s3_q;
    diff     = 12'd2048 - 12'(v);
    if (s3_neg) begin
      scale_tone = 11'd0;
    end else if (s3_big || (v < 11'd48)) begin
      scale_tone = TONE_LIMIT;
    end else begin
      scale_tone = diff[10:0];
    end
  end

  always_comb begin
    push        = s3_valid;
    work.up     = s3_up;
    work.ticks  = s3_ticks;
    work.mute   = s3_mute;
    work.cls    = s3_cls;
    work.tone   = s3_scale ? scale_tone : s3_smooth;
    work.period = s3_period;
  end

endmodule

`default_nettype wire

>>> rtl/vtg_queue.sv
`default_nettype none

module vtg_queue
  import vtg_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire vtg_work_t push_data,
  input  wire logic      pop,
  output logic           valid,
  output vtg_work_t      data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vtg_work_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign valid = count != '0;
  assign data  = entries[rd_ptr];

endmodule

`default_nettype wire

>>> rtl/vtg_back.sv
`default_nettype none

module vtg_back
  import vtg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire vtg_mode_t mode,
  input  wire logic      q_valid,
  input  wire vtg_work_t work,
  output logic           pop,
  output logic           result_valid,
  input  wire logic      result_stall,
  output vtg_result_t    result
);

  logic signed [15:0] last_climb;
  logic               last_valid;
  vtg_mode_t          last_mode;
  logic [7:0]         blink_period;
  logic [8:0]         blink_count;
  logic [10:0]        tone_reg;
  logic               sound_level;
  logic               written;

  logic signed [15:0] last_climb_next;
  logic               last_valid_next;
  vtg_mode_t          last_mode_next;
  logic [7:0]         blink_period_next;
  logic [8:0]         blink_count_next;
  logic [10:0]        tone_reg_next;
  logic               sound_level_next;
  logic               written_next;
  logic [8:0]         count_sum;

  always_comb begin
    pop               = q_valid && (!result_valid || !result_stall);
    last_climb_next   = last_climb;
    last_valid_next   = last_valid;
    last_mode_next    = last_mode;
    blink_period_next = blink_period;
    blink_count_next  = blink_count;
    tone_reg_next     = tone_reg;
    sound_level_next  = sound_level;
    written_next      = 1'b0;
    count_sum         = blink_count + 9'(work.ticks);
    if (work.mute) begin
      sound_level_next = 1'b0;
    end else begin
      if (!last_valid || (work.up != last_climb) || (mode != last_mode)) begin
        last_valid_next = 1'b1;
        last_climb_next = work.up;
        last_mode_next  = mode;
        unique case (work.cls)
          CLS_CLIMB: begin
            blink_period_next = work.period;
            tone_reg_next     = work.tone;
            written_next      = 1'b1;
          end
          CLS_SINK: begin
            blink_period_next = 8'd0;
            tone_reg_next     = work.tone;
            written_next      = 1'b1;
            sound_level_next  = 1'b1;
          end
          default: begin
            blink_period_next = 8'd0;
            sound_level_next  = 1'b0;
          end
        endcase
      end
      if (blink_period_next != 8'd0) begin
        if (count_sum > {1'b0, blink_period_next}) begin
          blink_count_next = 9'd0;
          sound_level_next = !sound_level_next;
        end else begin
          blink_count_next = count_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_climb   <= '0;
      last_valid   <= 1'b0;
      last_mode    <= MODE_OFF;
      blink_period <= '0;
      blink_count  <= '0;
      tone_reg     <= '0;
      sound_level  <= 1'b0;
      written      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        last_climb   <= last_climb_next;
        last_valid   <= last_valid_next;
        last_mode    <= last_mode_next;
        blink_period <= blink_period_next;
        blink_count  <= blink_count_next;
        tone_reg     <= tone_reg_next;
        sound_level  <= sound_level_next;
        written      <= written_next;
      end
      result_valid <= pop || (result_valid && result_stall);
    end
  end

  always_comb begin
    result.tone_value   = tone_reg;
    result.tone_written = written;
    result.sound_on     = sound_level;
  end

endmodule

`default_nettype wire

>>> rtl/vario_tone_generator.sv
// Variometer tone generator. Each transaction on the item channel carries one
// climb-rate update and yields exactly one result transaction with the tone
// register value, a flag telling whether the tone was rewritten, and the sound
// enable. The block sustains one transaction per clock cycle while the result
// channel is not stalled. That rate is set by the state update in the back end;
// the three-stage front end that computes candidate tones runs freely, and the
// queue between them must hold at least five entries for full rate. Item stall
// rises only when the queue and front end together hold QUEUE_DEPTH items.
// Configuration registers may be written only while no transaction is in
// flight.
`default_nettype none

module vario_tone_generator
  import vtg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire vtg_item_t   item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output vtg_result_t      result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  vtg_cfg_t         cfg;
  logic [CNT_W-1:0] credits;
  logic             accept;
  logic             push;
  vtg_work_t        push_data;
  logic             pop;
  logic             q_valid;
  vtg_work_t        q_data;

  assign cfg_ready  = 1'b1;
  assign item_stall = credits == CNT_W'(QUEUE_DEPTH);
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= MODE_OFF;
      cfg.climb_threshold <= CLIMB_THRESHOLD_RESET;
      cfg.sink_threshold  <= SINK_THRESHOLD_RESET;
      cfg.stop_mute       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TONE_MODE:       cfg.mode            <= vtg_mode_t'(cfg_data[1:0]);
        REG_CLIMB_THRESHOLD: cfg.climb_threshold <= cfg_data;
        REG_SINK_THRESHOLD:  cfg.sink_threshold  <= cfg_data;
        REG_STOP_MUTE:       cfg.stop_mute       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else if (accept && !pop) begin
      credits <= credits + 1'b1;
    end else if (pop && !accept) begin
      credits <= credits - 1'b1;
    end
  end

  vtg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .push   (push),
    .work   (push_data)
  );

  vtg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  vtg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .mode         (cfg.mode),
    .q_valid      (q_valid),
    .work         (q_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> rtl/vtg_checker.sv
`default_nettype none

module vtg_checker
  import vtg_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_stall,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire vtg_result_t result
);

  // Reset empties the output register.
  a_reset_result : assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // Reset returns every queue slot, so items are taken at once.
  a_reset_stall : assert property (@(posedge clk) rst |=> !item_stall)
    else $error("item_stall high after reset");

  a_result_hold : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result transaction changed");

  // A full queue drains one entry whenever the result side is not stalled.
  a_stall_release : assert property (@(posedge clk) disable iff (rst)
    item_stall && !result_stall |=> !item_stall)
    else $error("item_stall held while the result side was free");

endmodule

bind vario_tone_generator vtg_checker u_vtg_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import vtg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  vtg_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  vtg_result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_TONE_MODE;
  logic [15:0] cfg_data = '0;

  vario_tone_generator dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Register copies and tone state as the block should hold them.
  vtg_mode_t active_mode = MODE_OFF;
  int cur_climb_thr = 200;
  int cur_sink_thr = -2000;
  bit cur_stop_mute = 1'b0;

  int prev_up = 0;
  bit prev_known = 1'b0;
  vtg_mode_t prev_mode = MODE_OFF;
  logic [7:0] blink_len = '0;
  logic [8:0] blink_acc = '0;
  logic [10:0] tone_hold = '0;
  bit sound_hold = 1'b0;

  vtg_item_t update_queue[$];
  vtg_result_t expected_tones[$];

  logic item_fire = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_style = 0;
  int stall_span = 0;
  int idle_cycles = 0;
  int error_count = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int tones_rewritten = 0;
  int sound_on_count = 0;
  int register_writes = 0;

  function automatic int semitone_divisor(input int note);
    case (note)
      0: return 2004;
      1: return 1891;
      2: return 1785;
      3: return 1685;
      4: return 1591;
      5: return 1501;
      6: return 1417;
      7: return 1337;
      8: return 1262;
      9: return 1192;
      10: return 1125;
      default: return 1061;
    endcase
  endfunction

  function automatic logic [10:0] scale_tone_value(input int up, input int thr, input bit major);
    int x;
    int octave;
    int note;
    int v;
    int t;
    x = up + (major ? 4000 : 2000) - thr;
    if (x < 0) return 11'd0;
    if (major) begin
      note = (x % 2000) / 286;
      if (note > 6) note = 6;
      // The major scale steps are 0 2 4 5 7 9 11.
      note = 2 * note - ((note >= 3) ? 1 : 0);
      octave = x / 2000;
    end else begin
      note = (x % 1000) / 84;
      octave = x / 1000;
    end
    v = (octave >= 16) ? 0 : (semitone_divisor(note) >> octave);
    t = (v != 0) ? 2048 - v : 2047;
    return (t > 2000) ? 11'd2000 : t[10:0];
  endfunction

  function automatic vtg_result_t advance_vario(input vtg_item_t it);
    vtg_result_t r;
    int up;
    int t;
    int v;
    bit wrote;
    wrote = 1'b0;
    up = it.test_active ? $signed(it.test_climb) : $signed(it.measured_climb);
    if (active_mode == MODE_OFF ||
        (!it.test_active && (!it.fix_ok || (it.ground_stopped && cur_stop_mute)))) begin
      sound_hold = 1'b0;
    end else begin
      if (!prev_known || up != prev_up || active_mode != prev_mode) begin
        prev_known = 1'b1;
        prev_up = up;
        prev_mode = active_mode;
        if (up >= cur_climb_thr) begin
          t = 3840 - up / 2;
          blink_len = (t < 128) ? 8'd1 : 8'(t >> 7);
          if (active_mode == MODE_SMOOTH) begin
            v = 1600 + (up >>> 4);
            if (v > 2000) v = 2000;
            if (v < 0) v = 0;
            tone_hold = v[10:0];
          end else begin
            tone_hold = scale_tone_value(up, cur_climb_thr, active_mode == MODE_MAJOR);
          end
          wrote = 1'b1;
        end else if (up <= cur_sink_thr) begin
          blink_len = '0;
          if (active_mode == MODE_SMOOTH) begin
            v = 1500 + (up >>> 3);
            if (v < 0) v = 0;
            if (v > 2047) v = 2047;
            tone_hold = v[10:0];
          end else begin
            tone_hold = scale_tone_value(up, cur_sink_thr, active_mode == MODE_MAJOR);
          end
          wrote = 1'b1;
          sound_hold = 1'b1;
        end else begin
          blink_len = '0;
          sound_hold = 1'b0;
        end
      end
      if (blink_len != 0) begin
        blink_acc = blink_acc + 9'(it.elapsed_ticks);
        if (blink_acc > 9'(blink_len)) begin
          blink_acc = '0;
          sound_hold = ~sound_hold;
        end
      end
    end
    r.tone_value = tone_hold;
    r.tone_written = wrote;
    r.sound_on = sound_hold;
    return r;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_fire) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        item_valid <= 1'b0;
      end else if (update_queue.size() != 0) begin
        item <= update_queue.pop_front();
        item_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 12) : 0;
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_span = $urandom_range(16, 96);
    end else begin
      stall_span = stall_span - 1;
    end
    case (stall_style)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 1) == 1);
      2: result_stall <= (stall_span % 8 < 3);
      default: result_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin : monitor
    vtg_result_t want;
    if (rst) begin
      item_fire <= 1'b0;
    end else begin
      item_fire <= item_valid && !item_stall;
      if (item_valid && !item_stall) begin
        expected_tones.push_back(advance_vario(item));
        items_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        register_writes++;
        case (cfg_index)
          REG_TONE_MODE: active_mode = vtg_mode_t'(cfg_data[1:0]);
          REG_CLIMB_THRESHOLD: cur_climb_thr = $signed(cfg_data);
          REG_SINK_THRESHOLD: cur_sink_thr = $signed(cfg_data);
          default: cur_stop_mute = cfg_data[0];
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_tones.size() == 0) begin
          $display("%0t: result with no update pending: expected none, got %p", $time, result);
          error_count++;
        end else begin
          want = expected_tones.pop_front();
          results_checked++;
          if (result.tone_written) tones_rewritten++;
          if (result.sound_on) sound_on_count++;
          if (result.tone_value !== want.tone_value) begin
            $display("%0t: tone_value expected %0d, got %0d", $time, want.tone_value,
                     result.tone_value);
            error_count++;
          end
          if (result.tone_written !== want.tone_written) begin
            $display("%0t: tone_written expected %0d, got %0d", $time, want.tone_written,
                     result.tone_written);
            error_count++;
          end
          if (result.sound_on !== want.sound_on) begin
            $display("%0t: sound_on expected %0d, got %0d", $time, want.sound_on,
                     result.sound_on);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_register(input logic [1:0] idx, input int data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= data[15:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_setting(input vtg_mode_t mode, input int climb_thr, input int sink_thr,
                                 input bit stop_mute);
    write_register(REG_TONE_MODE, int'(mode));
    write_register(REG_CLIMB_THRESHOLD, climb_thr);
    write_register(REG_SINK_THRESHOLD, sink_thr);
    write_register(REG_STOP_MUTE, int'(stop_mute));
  endtask

  task automatic queue_update(input int meas, input int testc, input bit test_on, input bit fix,
                              input bit stopped, input int ticks);
    vtg_item_t it;
    it.measured_climb = meas[15:0];
    it.test_climb = testc[15:0];
    it.test_active = test_on;
    it.fix_ok = fix;
    it.ground_stopped = stopped;
    it.elapsed_ticks = ticks[7:0];
    update_queue.push_back(it);
  endtask

  // Mostly repeated or near-threshold climb rates so that the blink timer and
  // the no-change path get long runs, with full-range noise mixed in.
  task automatic queue_random_updates(input int count);
    int up;
    int pick;
    int other;
    bit test_on;
    up = 0;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick >= 35 && pick < 75) begin
        up = (($urandom_range(0, 1) == 1) ? cur_climb_thr : cur_sink_thr) +
             int'($urandom_range(0, 800)) - 400;
        if (up > 32767) up = 32767;
        if (up < -32768) up = -32768;
      end else if (pick >= 75) begin
        up = $signed(16'($urandom()));
      end
      other = $urandom();
      test_on = ($urandom_range(0, 3) == 0);
      queue_update(test_on ? other : up, test_on ? up : other, test_on,
                   $urandom_range(0, 11) != 0, $urandom_range(0, 3) == 0,
                   ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(0, 255));
    end
  endtask

  task automatic wait_for_drain();
    @(posedge clk);
    while (update_queue.size() != 0 || item_valid || expected_tones.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    vtg_mode_t mode;
    int climb_thr;
    int sink_thr;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: the mode is off, so the sound stays muted.
    queue_update(500, 0, 1'b0, 1'b1, 1'b0, 10);
    queue_update(0, -700, 1'b1, 1'b0, 1'b0, 0);
    wait_for_drain();

    program_setting(MODE_SMOOTH, 200, -2000, 1'b1);
    queue_update(500, 0, 1'b0, 1'b1, 1'b0, 255);
    queue_update(500, 0, 1'b0, 1'b1, 1'b0, 5);
    queue_update(-3000, 0, 1'b0, 1'b1, 1'b0, 0);
    queue_update(0, 0, 1'b0, 1'b1, 1'b0, 3);
    queue_update(500, 0, 1'b0, 1'b0, 1'b0, 1);
    queue_update(500, 0, 1'b0, 1'b1, 1'b1, 1);
    queue_update(-32768, 32767, 1'b1, 1'b0, 1'b1, 255);
    queue_update(-32768, 0, 1'b0, 1'b1, 1'b0, 0);
    wait_for_drain();

    // Both thresholds met: the climb case wins, and the smooth climb tone
    // saturates to zero at the bottom of the range.
    program_setting(MODE_SMOOTH, -32768, 32767, 1'b0);
    queue_update(-32768, 0, 1'b0, 1'b1, 1'b1, 2);
    queue_update(32767, 0, 1'b0, 1'b1, 1'b0, 255);
    wait_for_drain();

    program_setting(MODE_CHROMATIC, -32768, 32767, 1'b0);
    queue_update(32767, 0, 1'b0, 1'b1, 1'b0, 7);
    queue_update(-32768, 0, 1'b0, 1'b1, 1'b0, 7);
    wait_for_drain();

    program_setting(MODE_MAJOR, 32767, 32767, 1'b0);
    queue_update(32766, 0, 1'b0, 1'b1, 1'b0, 4);
    queue_update(32767, 0, 1'b0, 1'b1, 1'b0, 200);
    wait_for_drain();

    program_setting(MODE_SMOOTH, 32767, 32767, 1'b0);
    queue_update(32766, 0, 1'b0, 1'b1, 1'b0, 0);
    wait_for_drain();

    program_setting(MODE_CHROMATIC, 200, 0, 1'b0);
    queue_update(-5000, 0, 1'b0, 1'b1, 1'b0, 0);
    queue_update(150, 0, 1'b0, 1'b1, 1'b0, 9);
    queue_update(-1, 0, 1'b0, 1'b1, 1'b0, 0);
    wait_for_drain();

    for (int p = 0; p < 8; p++) begin
      mode = (p == 5) ? MODE_OFF : vtg_mode_t'(1 + (2 * p) % 3);
      climb_thr = int'($urandom_range(0, 2000)) - 500;
      sink_thr = -int'($urandom_range(0, 5000));
      if (p == 3) begin
        climb_thr = -32768;
        sink_thr = 32767;
      end else if (p == 6) begin
        climb_thr = 32767;
        sink_thr = -32768;
      end else if (p == 7) begin
        climb_thr = $signed(16'($urandom()));
        sink_thr = $signed(16'($urandom()));
      end
      program_setting(mode, climb_thr, sink_thr, $urandom_range(0, 1) == 1);
      queue_random_updates((p == 5) ? 40 : 240);
      wait_for_drain();
    end

    $display("Checked %0d results against %0d updates over %0d register writes.",
             results_checked, items_accepted, register_writes);
    $display("Tone rewritten %0d times, sound on in %0d results, %0d mismatches.",
             tones_rewritten, sound_on_count, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
